### rtl/rfar_pkg.sv
// Shared types and constants for the rotated frame align and reply block.
`timescale 1ns / 1ps

package rfar_pkg;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0]  MARK_A       = 8'hAA;
  localparam logic [7:0]  MARK_B       = 8'hBB;
  localparam logic [7:0]  HDR_BYTE     = 8'h01;
  localparam logic [7:0]  CMD_OFF      = 8'h00;
  localparam logic [7:0]  CMD_ON       = 8'h01;
  localparam logic [15:0] CMD_OFF_PAIR = 16'h3244;  // byte 5 = 0x44, byte 6 = 0x32
  localparam logic [15:0] CMD_ON_PAIR  = 16'h2413;  // byte 5 = 0x13, byte 6 = 0x24
  localparam logic [63:0] NO_MARK_FRAME = 64'h0500_0000_0000_0000;

  localparam int ERR_CHK  = 0;
  localparam int ERR_HDR  = 1;
  localparam int ERR_MARK = 2;

  // classified item, front to back
  typedef struct packed {
    logic [63:0] aligned;
    logic [2:0]  err;
    logic [63:0] tx_frame;
    logic        tx_valid;
  } cls_t;

  // finished result item
  typedef struct packed {
    logic [15:0] buttons;
    logic [2:0]  error_flags;
    logic [63:0] used_frame;
    logic [63:0] tx_frame;
    logic        tx_valid;
  } res_t;

endpackage

### rtl/rfar_fifo.sv
// Small register queue used between the stages and at the result side.
`timescale 1ns / 1ps

module rfar_fifo #(
  parameter int DEPTH = rfar_pkg::QUEUE_DEPTH,
  parameter int WIDTH = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_wr, do_rd;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    case ({do_wr, do_rd})
      2'b10:   count_nxt = count_r + CNT_W'(1);
      2'b01:   count_nxt = count_r - CNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

### rtl/rfar_front.sv
// Front: marker search, rotation, frame checks and reply frame build.
`timescale 1ns / 1ps

module rfar_front (
  input  logic [63:0]   rx_frame,
  input  logic [15:0]   led_cmd,
  input  logic [7:0]    firmware_cmd,
  input  logic          transmit_on,
  output rfar_pkg::cls_t cls
);

  logic [7:0]   rx_byte [8];
  logic [7:0]   hit;
  logic [2:0]   pos;
  logic         found;
  logic [127:0] dbl;
  logic [63:0]  rot;
  logic [63:0]  al;
  logic [7:0]   al_sum;
  logic [15:0]  cmd_pair;
  logic [7:0]   tx_sum;
  logic [7:0]   tx_chk;

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      rx_byte[k] = rx_frame[8*k +: 8];
    end
    for (int k = 0; k < 8; k++) begin
      hit[k] = (rx_byte[k] == rfar_pkg::MARK_A) && (rx_byte[(k + 1) % 8] == rfar_pkg::MARK_B);
    end
    // lowest position wins
    pos = '0;
    for (int k = 7; k >= 0; k--) begin
      if (hit[k]) begin
        pos = 3'(k);
      end
    end
  end

  assign found = |hit;
  assign dbl   = {rx_frame, rx_frame};
  assign rot   = dbl[{1'b0, pos, 3'b000} +: 64];
  assign al    = found ? rot : rfar_pkg::NO_MARK_FRAME;

  always_comb begin
    al_sum = '0;
    for (int k = 2; k < 8; k++) begin
      al_sum = al_sum + al[8*k +: 8];
    end
  end

  always_comb begin
    unique case (firmware_cmd)
      rfar_pkg::CMD_OFF: cmd_pair = rfar_pkg::CMD_OFF_PAIR;
      rfar_pkg::CMD_ON:  cmd_pair = rfar_pkg::CMD_ON_PAIR;
      default:           cmd_pair = '0;
    endcase
  end

  assign tx_sum = rfar_pkg::HDR_BYTE + ~led_cmd[15:8] + ~led_cmd[7:0]
                + cmd_pair[7:0] + cmd_pair[15:8];
  assign tx_chk = 8'h00 - tx_sum;

  always_comb begin
    cls.aligned                 = al;
    cls.err[rfar_pkg::ERR_CHK]  = (al_sum != 8'h00);
    cls.err[rfar_pkg::ERR_HDR]  = (al[23:16] != rfar_pkg::HDR_BYTE);
    cls.err[rfar_pkg::ERR_MARK] = !found;
    cls.tx_frame = {tx_chk, cmd_pair, ~led_cmd[7:0], ~led_cmd[15:8],
                    rfar_pkg::HDR_BYTE, rfar_pkg::MARK_A, rfar_pkg::MARK_B};
    cls.tx_valid = transmit_on;
  end

endmodule

### rtl/rfar_back.sv
// Back: picks aligned or stored frame, keeps the stored frame, forms the result.
`timescale 1ns / 1ps

module rfar_back (
  input  logic           clk,
  input  logic           rst_n,
  input  rfar_pkg::cls_t cls,
  input  logic           cls_valid,
  output logic           cls_pop,
  input  logic           res_full,
  output logic           res_push,
  output rfar_pkg::res_t res
);

  logic [63:0] prev_r, prev_nxt;
  logic [63:0] used;

  assign cls_pop  = cls_valid && !res_full;
  assign res_push = cls_pop;
  assign used     = (cls.err != '0) ? prev_r : cls.aligned;

  always_comb begin
    prev_nxt = prev_r;
    if (cls_pop) begin
      prev_nxt = used;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
    end else begin
      prev_r <= prev_nxt;
    end
  end

  always_comb begin
    res.buttons     = {used[31:24], used[39:32]};
    res.error_flags = cls.err;
    res.used_frame  = used;
    res.tx_frame    = cls.tx_frame;
    res.tx_valid    = cls.tx_valid;
  end

endmodule

### rtl/rotated_frame_align_and_reply.sv
// Top level of the rotated frame align and reply block.
//
//   channel  | handshake           | payload
//   ---------+---------------------+-----------------------------------------------
//   input    | push / full         | in_rx_frame, in_led_cmd, in_firmware_cmd,
//            |                     | in_transmit_on
//   result   | empty / pop         | out_buttons, out_error_flags, out_used_frame,
//            |                     | out_tx_frame, out_tx_valid
//
// One item per cycle sustained while the result side pops; the front classifies in the
// accept cycle into the middle queue; the back resolves it against the stored frame
// into the result queue.
// Reset clears both queues and the stored frame (all zeros).
// A stalled result side fills the result queue, then the middle queue, then full rises.
`timescale 1ns / 1ps

module rotated_frame_align_and_reply #(
  parameter int QUEUE_DEPTH = rfar_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [63:0] in_rx_frame,
  input  logic [15:0] in_led_cmd,
  input  logic [7:0]  in_firmware_cmd,
  input  logic        in_transmit_on,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] out_buttons,
  output logic [2:0]  out_error_flags,
  output logic [63:0] out_used_frame,
  output logic [63:0] out_tx_frame,
  output logic        out_tx_valid
);

  rfar_pkg::cls_t cls_in, cls_out;
  rfar_pkg::res_t res_in, res_out;
  logic           mid_empty, cls_pop, res_full, res_push;

  rfar_front u_front (
    .rx_frame     (in_rx_frame),
    .led_cmd      (in_led_cmd),
    .firmware_cmd (in_firmware_cmd),
    .transmit_on  (in_transmit_on),
    .cls          (cls_in)
  );

  rfar_fifo #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH ($bits(rfar_pkg::cls_t))
  ) u_mid_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push),
    .wr_data (cls_in),
    .full    (full),
    .rd_en   (cls_pop),
    .rd_data (cls_out),
    .empty   (mid_empty)
  );

  rfar_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cls       (cls_out),
    .cls_valid (!mid_empty),
    .cls_pop   (cls_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  rfar_fifo #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH ($bits(rfar_pkg::res_t))
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_push),
    .wr_data (res_in),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (res_out),
    .empty   (empty)
  );

  assign out_buttons     = res_out.buttons;
  assign out_error_flags = res_out.error_flags;
  assign out_used_frame  = res_out.used_frame;
  assign out_tx_frame    = res_out.tx_frame;
  assign out_tx_valid    = res_out.tx_valid;

endmodule

### rtl/rfar_checker.sv
// Port-level checks for the rotated frame align and reply block, bound to the top.
`timescale 1ns / 1ps

module rfar_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [15:0] out_buttons,
  input logic [2:0]  out_error_flags,
  input logic [63:0] out_used_frame,
  input logic [63:0] out_tx_frame
);

  // both queues come out of reset drained
  a_reset_clear: assert property (@(posedge clk) !rst_n |=> empty && !full)
    else $error("queues not clear after reset");

  // a missing marker always fails header and checksum as well
  a_mark_implies_all: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_error_flags[rfar_pkg::ERR_MARK] |-> out_error_flags[1:0] == 2'b11)
    else $error("marker error without header and checksum errors");

  // a clean item carries the marker and header at the front
  a_clean_frame: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_error_flags == 3'd0 |->
      out_used_frame[7:0] == rfar_pkg::MARK_A && out_used_frame[15:8] == rfar_pkg::MARK_B &&
      out_used_frame[23:16] == rfar_pkg::HDR_BYTE)
    else $error("clean item without marker or header");

  a_buttons: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> out_buttons == {out_used_frame[31:24], out_used_frame[39:32]} &&
      out_tx_frame[23:0] == {rfar_pkg::HDR_BYTE, rfar_pkg::MARK_A, rfar_pkg::MARK_B})
    else $error("buttons or reply header do not match");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty && $stable(out_used_frame))
    else $error("waiting item changed");

endmodule

bind rotated_frame_align_and_reply rfar_checker u_rfar_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .full            (full),
  .empty           (empty),
  .pop             (pop),
  .out_buttons     (out_buttons),
  .out_error_flags (out_error_flags),
  .out_used_frame  (out_used_frame),
  .out_tx_frame    (out_tx_frame)
);

### test/rfar_score_pkg.sv
// Scoreboard for the frame align and reply block: predicts each result and checks it.
`timescale 1ns / 1ps

package rfar_score_pkg;

  import rfar_pkg::*;

  class frame_scoreboard;
    res_t        expected_q[$];
    logic [63:0] last_good_frame;
    int          errors;
    int          frames_noted;
    int          results_checked;
    int          flagged_results;

    function new();
      last_good_frame = '0;
      errors          = 0;
      frames_noted    = 0;
      results_checked = 0;
      flagged_results = 0;
    endfunction

    // works out the result of one accepted poll and queues it
    function void note_input(logic [63:0] rx, logic [15:0] led, logic [7:0] fw, logic ton);
      logic [127:0] doubled;
      logic [63:0]  aligned;
      logic [7:0]   byte_sum;
      logic [7:0]   reply_sum;
      logic [15:0]  cmd_pair;
      logic [2:0]   flags;
      bit           found;
      int           pos;
      res_t         want;
      found = 1'b0;
      pos   = 0;
      for (int k = 0; k < 8; k++) begin
        if (!found && rx[8*k +: 8] == MARK_A && rx[8*((k + 1) % 8) +: 8] == MARK_B) begin
          found = 1'b1;
          pos   = k;
        end
      end
      doubled = {rx, rx};
      aligned = found ? doubled[8*pos +: 64] : NO_MARK_FRAME;
      byte_sum = '0;
      for (int k = 2; k < 8; k++) byte_sum += aligned[8*k +: 8];
      flags           = '0;
      flags[ERR_CHK]  = (byte_sum != 8'h00);
      flags[ERR_HDR]  = (aligned[23:16] != HDR_BYTE);
      flags[ERR_MARK] = !found;
      // a bad frame leaves the stored one in place
      if (flags == '0) last_good_frame = aligned;
      case (fw)
        CMD_OFF: cmd_pair = CMD_OFF_PAIR;
        CMD_ON:  cmd_pair = CMD_ON_PAIR;
        default: cmd_pair = 16'h0000;
      endcase
      reply_sum = HDR_BYTE + (~led[15:8]) + (~led[7:0]) + cmd_pair[7:0] + cmd_pair[15:8];
      want.buttons     = {last_good_frame[31:24], last_good_frame[39:32]};
      want.error_flags = flags;
      want.used_frame  = last_good_frame;
      want.tx_frame    = {8'h00 - reply_sum, cmd_pair, ~led[7:0], ~led[15:8],
                          HDR_BYTE, MARK_A, MARK_B};
      want.tx_valid    = ton;
      expected_q.push_back(want);
      frames_noted++;
    endfunction

    function void check_result(res_t got);
      res_t want;
      results_checked++;
      if (expected_q.size() == 0) begin
        $error("unexpected result item: used_frame %h", got.used_frame);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (want.error_flags != '0) flagged_results++;
      if (got.buttons !== want.buttons) begin
        $error("buttons: expected %h, got %h", want.buttons, got.buttons);
        errors++;
      end
      if (got.error_flags !== want.error_flags) begin
        $error("error_flags: expected %b, got %b", want.error_flags, got.error_flags);
        errors++;
      end
      if (got.used_frame !== want.used_frame) begin
        $error("used_frame: expected %h, got %h", want.used_frame, got.used_frame);
        errors++;
      end
      if (got.tx_frame !== want.tx_frame) begin
        $error("tx_frame: expected %h, got %h", want.tx_frame, got.tx_frame);
        errors++;
      end
      if (got.tx_valid !== want.tx_valid) begin
        $error("tx_valid: expected %b, got %b", want.tx_valid, got.tx_valid);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

endpackage

### test/tb_top.sv
// Top-level testbench: drives polls into the frame align and reply block and checks results.
`timescale 1ns / 1ps

module tb_top;

  import rfar_pkg::*;
  import rfar_score_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int RANDOM_POLLS = 1550;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [63:0] in_rx_frame = '0;
  logic [15:0] in_led_cmd = '0;
  logic [7:0]  in_firmware_cmd = '0;
  logic        in_transmit_on = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [15:0] out_buttons;
  logic [2:0]  out_error_flags;
  logic [63:0] out_used_frame;
  logic [63:0] out_tx_frame;
  logic        out_tx_valid;

  frame_scoreboard sb;
  bit              no_idle = 1'b0;
  res_t            seen;

  rotated_frame_align_and_reply u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_rx_frame     (in_rx_frame),
    .in_led_cmd      (in_led_cmd),
    .in_firmware_cmd (in_firmware_cmd),
    .in_transmit_on  (in_transmit_on),
    .empty           (empty),
    .pop             (pop),
    .out_buttons     (out_buttons),
    .out_error_flags (out_error_flags),
    .out_used_frame  (out_used_frame),
    .out_tx_frame    (out_tx_frame),
    .out_tx_valid    (out_tx_valid)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // mostly random bytes, with the marker bytes thrown in now and then
  function automatic logic [7:0] rand_byte();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return MARK_A;
    if (pick == 1) return MARK_B;
    return 8'($urandom);
  endfunction

  // aligned frame: AA BB hdr b3 b4 b5 b6 chk, byte 0 low
  function automatic logic [63:0] build_aligned(logic [7:0] hdr, logic [7:0] b3,
                                                logic [7:0] b4, logic [7:0] b5,
                                                logic [7:0] b6, bit bad_sum);
    logic [7:0] chk;
    chk = 8'h00 - (hdr + b3 + b4 + b5 + b6);
    if (bad_sum) chk = chk + 8'($urandom_range(1, 255));
    return {chk, b6, b5, b4, b3, hdr, MARK_B, MARK_A};
  endfunction

  // places aligned byte 0 at received position pos
  function automatic logic [63:0] wrap_frame(logic [63:0] aligned, int pos);
    logic [127:0] doubled;
    doubled = {aligned, aligned};
    return doubled[64 - 8*pos +: 64];
  endfunction

  task automatic send_frame(logic [63:0] rx, logic [15:0] led, logic [7:0] fw, logic ton);
    while (!no_idle && $urandom_range(0, 99) < 12) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push            <= 1'b1;
    in_rx_frame     <= rx;
    in_led_cmd      <= led;
    in_firmware_cmd <= fw;
    in_transmit_on  <= ton;
    do @(posedge clk); while (full);
    sb.note_input(rx, led, fw, ton);
  endtask

  // result side: check on acceptance, then decide whether to stall next cycle
  always @(posedge clk) begin
    if (rst_n && pop && !empty) begin
      seen.buttons     = out_buttons;
      seen.error_flags = out_error_flags;
      seen.used_frame  = out_used_frame;
      seen.tx_frame    = out_tx_frame;
      seen.tx_valid    = out_tx_valid;
      sb.check_result(seen);
    end
    pop <= no_idle || ($urandom_range(0, 99) >= 12);
  end

  initial begin
    int stalled;
    stalled = 0;
    while (stalled < STALL_LIMIT) begin
      @(posedge clk);
      if ((push && !full) || (pop && !empty)) stalled = 0;
      else stalled++;
    end
    $display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    logic [63:0] frame;
    logic [7:0]  hdr;
    logic [7:0]  fw_val;
    bit          bad;
    int          kind;
    sb = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // extremes, no marker at all
    send_frame(64'h0, 16'h0000, CMD_OFF, 1'b0);
    send_frame('1, 16'hFFFF, CMD_ON, 1'b1);
    // a good frame at every rotation, including the wrap from byte 7 to byte 0
    for (int p = 0; p < 8; p++) begin
      frame = build_aligned(HDR_BYTE, rand_byte(), rand_byte(), rand_byte(), rand_byte(), 1'b0);
      case (p % 4)
        0: fw_val = CMD_OFF;
        1: fw_val = CMD_ON;
        2: fw_val = 8'h02;
        default: fw_val = 8'hFF;
      endcase
      send_frame(wrap_frame(frame, p), (p % 2) ? 16'hFFFF : 16'($urandom), fw_val,
                 1'(p % 2));
    end
    // checksum only, header only, then both
    send_frame(wrap_frame(build_aligned(HDR_BYTE, 8'h12, 8'h34, 8'h56, 8'h78, 1'b1), 3),
               16'h0000, CMD_ON, 1'b1);
    send_frame(wrap_frame(build_aligned(8'h02, 8'h12, 8'h34, 8'h56, 8'h78, 1'b0), 5),
               16'h8001, CMD_OFF, 1'b0);
    send_frame(wrap_frame(build_aligned(8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 1'b1), 6),
               16'h7FFE, 8'h80, 1'b1);
    // two markers: the lower position must win
    send_frame(wrap_frame(build_aligned(HDR_BYTE, MARK_A, MARK_B, 8'h00, 8'hFF, 1'b0), 0),
               16'h1234, CMD_ON, 1'b1);
    send_frame(wrap_frame(build_aligned(HDR_BYTE, 8'h00, 8'h00, MARK_A, MARK_B, 1'b0), 2),
               16'hABCD, CMD_OFF, 1'b0);
    send_frame(wrap_frame(build_aligned(HDR_BYTE, 8'h00, 8'h00, MARK_A, MARK_B, 1'b0), 4),
               16'h5555, CMD_ON, 1'b1);
    // marker bytes in the wrong order, and a lone AA
    send_frame(64'h0101_0101_0101_AABB, 16'hAAAA, 8'h7F, 1'b0);
    send_frame(64'h00AA_0000_0000_0000, 16'h0F0F, CMD_OFF, 1'b1);
    // a clean frame again after the errors
    send_frame(wrap_frame(build_aligned(HDR_BYTE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0), 1),
               16'hF0F0, CMD_ON, 1'b0);

    for (int n = 0; n < RANDOM_POLLS; n++) begin
      no_idle = (n >= 500 && n < 800);
      kind = $urandom_range(0, 99);
      hdr  = HDR_BYTE;
      bad  = 1'b0;
      if (kind < 15) begin
        frame = {$urandom, $urandom};
      end else begin
        if (kind < 25) bad = 1'b1;
        else if (kind < 32) hdr = rand_byte();
        frame = wrap_frame(build_aligned(hdr, rand_byte(), rand_byte(), rand_byte(),
                                         rand_byte(), bad), $urandom_range(0, 7));
      end
      case ($urandom_range(0, 3))
        0: fw_val = CMD_OFF;
        1: fw_val = CMD_ON;
        default: fw_val = 8'($urandom);
      endcase
      send_frame(frame, 16'($urandom), fw_val, 1'($urandom_range(0, 1)));
    end
    no_idle = 1'b0;
    push <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);

    $display("Summary: %0d polls sent, %0d results checked, %0d of them flagged bad",
             sb.frames_noted, sb.results_checked, sb.flagged_results);
    $display("Mismatches: %0d", sb.errors);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
